>>> hdl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared widths, constants and types of the switched PI/PD controller.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int ANGLE_W   = 17;
    localparam int ERR_W     = 18;
    localparam int DELTA_W   = 19;
    localparam int GAIN_W    = 16;
    localparam int BAND_W    = 17;
    localparam int TICKS_W   = 8;
    localparam int INTEG_W   = 32;
    localparam int X_W       = 32;
    localparam int NUM_W     = 50;
    localparam int MAG_W     = 49;
    localparam int DEN_W     = 14;
    localparam int DRIVE_W   = 16;
    localparam int MAC_CNT_W = 4;
    localparam int DIV_CNT_W = 6;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = ADDR_W - 2;

    localparam logic [DEN_W-1:0]   DEN_PI      = 14'd12800;
    localparam logic [DEN_W-1:0]   DEN_PD      = 14'd256;
    localparam logic [DRIVE_W-1:0] DRIVE_LIMIT = 16'd25600;

    localparam logic signed [INTEG_W:0] INTEG_HI = 33'sd2147483647;
    localparam logic signed [INTEG_W:0] INTEG_LO = -33'sd2147483647;
    localparam logic [INTEG_W-1:0]      INTEG_MIN_CODE = 32'h8000_0000;

    localparam logic [GAIN_W-1:0]  KP_TRANSIENT_RST = 16'd256;
    localparam logic [GAIN_W-1:0]  KI_GAIN_RST      = 16'd26;
    localparam logic [GAIN_W-1:0]  KP_STEADY_RST    = 16'd256;
    localparam logic [GAIN_W-1:0]  KD_GAIN_RST      = 16'd26;
    localparam logic [BAND_W-1:0]  ERROR_BAND_RST   = 17'd1280;
    localparam logic [TICKS_W-1:0] STABLE_TICKS_RST = 8'd10;

    typedef enum logic [IDX_W-1:0] {
        REG_KP_TRANSIENT = 3'd0,
        REG_KI_GAIN      = 3'd1,
        REG_KP_STEADY    = 3'd2,
        REG_KD_GAIN      = 3'd3,
        REG_ERROR_BAND   = 3'd4,
        REG_STABLE_TICKS = 3'd5
    } spd_reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MUL    = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } spd_state_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp_transient;
        logic [GAIN_W-1:0]  ki_gain;
        logic [GAIN_W-1:0]  kp_steady;
        logic [GAIN_W-1:0]  kd_gain;
        logic [BAND_W-1:0]  error_band;
        logic [TICKS_W-1:0] stable_ticks;
    } spd_cfg_t;

    typedef struct packed {
        logic                  start;
        logic [GAIN_W-1:0]     gain_a;
        logic signed [X_W-1:0] x_a;
        logic [GAIN_W-1:0]     gain_b;
        logic signed [X_W-1:0] x_b;
    } spd_mac_req_t;

endpackage

>>> hdl/spd_regs.sv
// ----------------------------------------------------------------------------
// spd_regs
// APB register file holding the controller gains, error band and tick count.
// ----------------------------------------------------------------------------
module spd_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spd_pkg::ADDR_W-1:0]  paddr,
    input  logic [spd_pkg::DATA_W-1:0]  pwdata,
    output logic [spd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output spd_pkg::spd_cfg_t           cfg
);
    import spd_pkg::*;

    spd_cfg_t         cfg_reg;
    spd_cfg_t         cfg_next;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_KP_TRANSIENT: cfg_next.kp_transient = pwdata[GAIN_W-1:0];
                REG_KI_GAIN:      cfg_next.ki_gain      = pwdata[GAIN_W-1:0];
                REG_KP_STEADY:    cfg_next.kp_steady    = pwdata[GAIN_W-1:0];
                REG_KD_GAIN:      cfg_next.kd_gain      = pwdata[GAIN_W-1:0];
                REG_ERROR_BAND:   cfg_next.error_band   = pwdata[BAND_W-1:0];
                REG_STABLE_TICKS: cfg_next.stable_ticks = pwdata[TICKS_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_KP_TRANSIENT: prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.kp_transient};
            REG_KI_GAIN:      prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.ki_gain};
            REG_KP_STEADY:    prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.kp_steady};
            REG_KD_GAIN:      prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.kd_gain};
            REG_ERROR_BAND:   prdata = {{(DATA_W-BAND_W){1'b0}}, cfg_reg.error_band};
            REG_STABLE_TICKS: prdata = {{(DATA_W-TICKS_W){1'b0}}, cfg_reg.stable_ticks};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_transient <= KP_TRANSIENT_RST;
            cfg_reg.ki_gain      <= KI_GAIN_RST;
            cfg_reg.kp_steady    <= KP_STEADY_RST;
            cfg_reg.kd_gain      <= KD_GAIN_RST;
            cfg_reg.error_band   <= ERROR_BAND_RST;
            cfg_reg.stable_ticks <= STABLE_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/spd_mac.sv
// ----------------------------------------------------------------------------
// spd_mac
// Bit-serial multiply-accumulate: gain_a*x_a + gain_b*x_b, one gain bit a cycle.
// ----------------------------------------------------------------------------
module spd_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spd_pkg::spd_mac_req_t            req,
    output logic                             done,
    output logic signed [spd_pkg::NUM_W-1:0] acc
);
    import spd_pkg::*;

    logic                  busy_reg,   busy_next;
    logic                  phase_reg,  phase_next;
    logic                  done_reg,   done_next;
    logic [MAC_CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [GAIN_W-1:0]     gain_reg,   gain_next;
    logic [GAIN_W-1:0]     gain_b_reg, gain_b_next;
    logic signed [X_W-1:0] x_b_reg,    x_b_next;
    logic signed [NUM_W-1:0] x_reg,    x_next;
    logic signed [NUM_W-1:0] acc_reg,  acc_next;

    assign done = done_reg;
    assign acc  = acc_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        phase_next  = phase_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        gain_next   = gain_reg;
        gain_b_next = gain_b_reg;
        x_b_next    = x_b_reg;
        x_next      = x_reg;
        acc_next    = acc_reg;
        if (req.start)
        begin
            busy_next   = 1'b1;
            phase_next  = 1'b0;
            cnt_next    = '0;
            gain_next   = req.gain_a;
            x_next      = {{(NUM_W-X_W){req.x_a[X_W-1]}}, req.x_a};
            acc_next    = '0;
            gain_b_next = req.gain_b;
            x_b_next    = req.x_b;
        end
        else if (busy_reg)
        begin
            if (gain_reg[0])
            begin
                acc_next = acc_reg + x_reg;
            end
            gain_next = {1'b0, gain_reg[GAIN_W-1:1]};
            x_next    = {x_reg[NUM_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == MAC_CNT_W'(GAIN_W-1))
            begin
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    cnt_next   = '0;
                    gain_next  = gain_b_reg;
                    x_next     = {{(NUM_W-X_W){x_b_reg[X_W-1]}}, x_b_reg};
                end
                else
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gain_reg   <= gain_next;
        gain_b_reg <= gain_b_next;
        x_b_reg    <= x_b_next;
        x_reg      <= x_next;
        acc_reg    <= acc_next;
    end

endmodule

>>> hdl/spd_div.sv
// ----------------------------------------------------------------------------
// spd_div
// Bit-serial restoring divider with round-half-away and drive saturation.
// ----------------------------------------------------------------------------
module spd_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [spd_pkg::NUM_W-1:0]   num,
    input  logic                               pd_mode,
    output logic                               done,
    output logic signed [spd_pkg::DRIVE_W-1:0] drive
);
    import spd_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [MAG_W-1:0]     dvd_reg,  dvd_next;
    logic [DEN_W-1:0]     rem_reg,  rem_next;
    logic [DEN_W-1:0]     den_reg,  den_next;
    logic [DRIVE_W-1:0]   q_reg,    q_next;
    logic                 ovf_reg,  ovf_next;
    logic                 neg_reg,  neg_next;

    logic [DEN_W-1:0]        den_sel;
    logic [DEN_W-1:0]        half;
    logic signed [NUM_W-1:0] half_ext;
    logic signed [NUM_W-1:0] mag_full;
    logic [DEN_W:0]          r_shift;
    logic [DEN_W:0]          r_diff;
    logic                    ge;
    logic [DRIVE_W-1:0]      q_sat;

    assign den_sel  = pd_mode ? DEN_PD : DEN_PI;
    assign half     = {1'b0, den_sel[DEN_W-1:1]};
    assign half_ext = $signed({{(NUM_W-DEN_W){1'b0}}, half});
    assign mag_full = num[NUM_W-1] ? (half_ext - num) : (num + half_ext);

    assign r_shift = {rem_reg, dvd_reg[MAG_W-1]};
    assign ge      = r_shift >= {1'b0, den_reg};
    assign r_diff  = r_shift - {1'b0, den_reg};

    assign q_sat = (ovf_reg || (q_reg > DRIVE_LIMIT)) ? DRIVE_LIMIT : q_reg;
    assign drive = $signed(neg_reg ? (DRIVE_W'(0) - q_sat) : q_sat);
    assign done  = done_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = mag_full[MAG_W-1:0];
            rem_next  = '0;
            den_next  = den_sel;
            q_next    = '0;
            ovf_next  = 1'b0;
            neg_next  = num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[MAG_W-2:0], 1'b0};
            rem_next = ge ? r_diff[DEN_W-1:0] : r_shift[DEN_W-1:0];
            q_next   = {q_reg[DRIVE_W-2:0], ge};
            ovf_next = ovf_reg | q_reg[DRIVE_W-1];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(MAG_W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
    end

endmodule

>>> hdl/switched_pi_pd_controller_top.sv
// ----------------------------------------------------------------------------
// switched_pi_pd_controller_top
// Each accepted transaction runs through the bit-serial multiply-accumulate and
// then the bit-serial divider; a new transaction is taken only in idle, once the
// previous result has moved into the output register.
// The next transaction is taken while a finished result waits at the output.
// Reset: asynchronous, active low; gains and thresholds return to defaults,
// error history, integral and stable count clear to zero.
// ----------------------------------------------------------------------------
module switched_pi_pd_controller_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [spd_pkg::ANGLE_W-1:0]         target_angle,
    input  logic [spd_pkg::ANGLE_W-1:0]         measured_angle,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [spd_pkg::DRIVE_W-1:0]  drive,
    output logic                                steady_mode,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spd_pkg::ADDR_W-1:0]          paddr,
    input  logic [spd_pkg::DATA_W-1:0]          pwdata,
    output logic [spd_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);
    import spd_pkg::*;

    spd_cfg_t     cfg;
    spd_mac_req_t mac_req;
    logic                    mac_done;
    logic signed [NUM_W-1:0] mac_acc;
    logic                    div_start;
    logic                    div_done;
    logic signed [DRIVE_W-1:0] div_drive;

    spd_state_t state_reg, state_next;
    logic signed [ERR_W-1:0]   last_error_reg, last_error_next;
    logic signed [INTEG_W-1:0] integral_reg,   integral_next;
    logic [TICKS_W-1:0]        counter_reg,    counter_next;
    logic                      steady_reg,     steady_next;
    logic                      out_valid_reg,  out_valid_next;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic                      steady_out_reg;

    logic                      accept;
    logic                      out_load;
    logic signed [ERR_W-1:0]   err;
    logic signed [DELTA_W-1:0] delta;
    logic [ERR_W-1:0]          mag;
    logic                      in_band;
    logic [TICKS_W-1:0]        cnt_upd;
    logic                      steady_new;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [X_W-1:0]     e32;
    logic signed [X_W-1:0]     e50;
    logic signed [X_W-1:0]     d32;
    logic signed [X_W-1:0]     d50;

    spd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .done  (mac_done),
        .acc   (mac_acc)
    );

    spd_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num     (mac_acc),
        .pd_mode (steady_reg),
        .done    (div_done),
        .drive   (div_drive)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign drive       = drive_reg;
    assign steady_mode = steady_out_reg;
    assign div_start   = (state_reg == ST_MUL) && mac_done;
    assign out_load    = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    assign err   = $signed({1'b0, target_angle}) - $signed({1'b0, measured_angle});
    assign delta = $signed({err[ERR_W-1], err})
                 - $signed({last_error_reg[ERR_W-1], last_error_reg});
    assign mag     = err[ERR_W-1] ? (ERR_W'(0) - err) : err;
    assign in_band = mag < {1'b0, cfg.error_band};

    always_comb
    begin
        if (!in_band)
        begin
            cnt_upd = '0;
        end
        else if (counter_reg < cfg.stable_ticks)
        begin
            cnt_upd = counter_reg + 1'b1;
        end
        else
        begin
            cnt_upd = cfg.stable_ticks;
        end
    end

    assign steady_new = cnt_upd >= cfg.stable_ticks;

    assign integ_sum = $signed({integral_reg[INTEG_W-1], integral_reg})
                     + $signed({{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err});

    always_comb
    begin
        if (integ_sum > INTEG_HI)
        begin
            integ_sat = INTEG_HI[INTEG_W-1:0];
        end
        else if (integ_sum < INTEG_LO)
        begin
            integ_sat = INTEG_LO[INTEG_W-1:0];
        end
        else
        begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
    end

    assign e32 = $signed({{(X_W-ERR_W){err[ERR_W-1]}}, err});
    assign d32 = $signed({{(X_W-DELTA_W){delta[DELTA_W-1]}}, delta});
    assign e50 = (e32 <<< 5) + (e32 <<< 4) + (e32 <<< 1);
    assign d50 = (d32 <<< 5) + (d32 <<< 4) + (d32 <<< 1);

    always_comb
    begin
        mac_req.start  = accept;
        mac_req.gain_a = steady_new ? cfg.kp_steady : cfg.kp_transient;
        mac_req.x_a    = steady_new ? e32 : e50;
        mac_req.gain_b = steady_new ? cfg.kd_gain : cfg.ki_gain;
        mac_req.x_b    = steady_new ? d50 : integ_sat;
    end

    always_comb
    begin
        state_next      = state_reg;
        last_error_next = last_error_reg;
        integral_next   = integral_reg;
        counter_next    = counter_reg;
        steady_next     = steady_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_error_next = err;
                    counter_next    = cnt_upd;
                    steady_next     = steady_new;
                    if (!steady_new)
                    begin
                        integral_next = integ_sat;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mac_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_error_reg <= '0;
            integral_reg   <= '0;
            counter_reg    <= '0;
            steady_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_error_reg <= last_error_next;
            integral_reg   <= integral_next;
            counter_reg    <= counter_next;
            steady_reg     <= steady_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            drive_reg      <= div_drive;
            steady_out_reg <= steady_reg;
        end
    end

    a_mac_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == ST_MUL)
        else $error("multiply finished outside the multiply phase");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divide finished outside the divide phase");

    a_integral_floor: assert property (@(posedge clk) disable iff (!rst_n)
        integral_reg != $signed(INTEG_MIN_CODE))
        else $error("integral reached the unclamped negative limit");

    a_pd_freezes_integral: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && steady_new) |=> integral_reg == $past(integral_reg))
        else $error("integral moved on a PD transaction");

    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && (drive_reg <= $signed(DRIVE_LIMIT))
                     && (drive_reg >= -$signed(DRIVE_LIMIT)))
        else $error("drive result outside the saturation limits");

endmodule

>>> tb/tb_switched_pi_pd_controller_top.sv
// ----------------------------------------------------------------------------
// tb_switched_pi_pd_controller_top
// Self-checking bench for the switched PI/PD controller: a short table of
// directed ticks, random phases under several gain and threshold settings,
// and a short run of full-scale errors with a unit integral gain. Every result
// is compared against an in-bench model of the controller or against a value
// pinned in the table; register writes go through the APB port and are read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_switched_pi_pd_controller_top;

    import spd_pkg::*;

    localparam int        ANGLE_MAX   = 131071;
    localparam int        CYCLE_LIMIT = 1000000;
    localparam int        HOLD_CYCLES = 400;
    localparam int        PHASE_ITEMS = 75;
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd6;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        int        a;
        int        b;
        bit        pinned;
        int        drive;
        bit        mode;
    } plan_row_t;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic                      mode;
    } drive_result_t;

    typedef struct {
        bit            on;
        drive_result_t res;
    } pinned_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [ANGLE_W-1:0]         target_angle;
    logic [ANGLE_W-1:0]         measured_angle;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [DRIVE_W-1:0]  drive;
    logic                       steady_mode;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    logic [GAIN_W-1:0]  cfg_kp_tr;
    logic [GAIN_W-1:0]  cfg_ki;
    logic [GAIN_W-1:0]  cfg_kp_st;
    logic [GAIN_W-1:0]  cfg_kd;
    logic [BAND_W-1:0]  cfg_band;
    logic [TICKS_W-1:0] cfg_ticks;

    int     prev_error;
    longint integ_acc;
    int     stable_run;

    drive_result_t  pending_results[$];
    pinned_result_t pinned_q[$];
    plan_row_t      plan[$];

    int fail_count;
    int cycle_count;
    int stall_request;
    bit tx_gaps_on;
    bit rx_gaps_on;

    switched_pi_pd_controller_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .target_angle   (target_angle),
        .measured_angle (measured_angle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive          (drive),
        .steady_mode    (steady_mode),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 5);
        else
            return $urandom_range(15, 60);
    endfunction

    function automatic plan_row_t step_row(row_kind_t kind, int a, int b, bit pinned,
                                           int drv, bit mode);
        plan_row_t r;
        r.kind   = kind;
        r.a      = a;
        r.b      = b;
        r.pinned = pinned;
        r.drive  = drv;
        r.mode   = mode;
        return r;
    endfunction

    // one control tick of the controller, updating the tracked state
    function automatic drive_result_t advance_controller(logic [ANGLE_W-1:0] tgt,
                                                         logic [ANGLE_W-1:0] meas);
        int            t;
        int            m;
        int            err;
        int            delta;
        int            mag;
        int            band;
        int            ticks;
        longint        kp;
        longint        kx;
        longint        num;
        longint        den;
        longint        q;
        longint        drv;
        longint        cap;
        longint        lim;
        drive_result_t r;
        t     = int'(tgt);
        m     = int'(meas);
        err   = t - m;
        delta = err - prev_error;
        mag   = (err < 0) ? -err : err;
        band  = int'(cfg_band);
        ticks = int'(cfg_ticks);
        cap   = longint'(DRIVE_LIMIT);
        lim   = longint'(INTEG_HI);
        if (mag < band)
        begin
            if (stable_run < ticks)
                stable_run++;
            else
                stable_run = ticks;
        end
        else
        begin
            stable_run = 0;
        end
        r.mode = (stable_run >= ticks);
        if (r.mode)
        begin
            kp  = longint'(cfg_kp_st);
            kx  = longint'(cfg_kd);
            num = kp * err + kx * delta * 50;
            den = longint'(DEN_PD);
        end
        else
        begin
            integ_acc += err;
            if (integ_acc > lim)
                integ_acc = lim;
            if (integ_acc < -lim)
                integ_acc = -lim;
            kp  = longint'(cfg_kp_tr);
            kx  = longint'(cfg_ki);
            num = kp * err * 50 + kx * integ_acc;
            den = longint'(DEN_PI);
        end
        q   = (((num < 0) ? -num : num) + den / 2) / den;
        drv = (num < 0) ? -q : q;
        if (drv > cap)
            drv = cap;
        if (drv < -cap)
            drv = -cap;
        prev_error = err;
        r.drive    = 16'(drv);
        return r;
    endfunction

    // accept results, then track accepted transactions
    always @(posedge clk)
    begin
        drive_result_t  want;
        drive_result_t  calc;
        pinned_result_t pin;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no expectation waiting: drive %0d steady_mode %0d",
                           drive, steady_mode);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (drive !== want.drive)
                    begin
                        $error("drive: expected %0d, got %0d", want.drive, drive);
                        fail_count++;
                    end
                    if (steady_mode !== want.mode)
                    begin
                        $error("steady_mode: expected %0d, got %0d", want.mode, steady_mode);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                calc = advance_controller(target_angle, measured_angle);
                pin  = pinned_q.pop_front();
                pending_results.push_back(pin.on ? pin.res : calc);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("switched_pi_pd_controller_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        int n;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            n = 0;
            if (stall_request > 0)
            begin
                n = stall_request;
                stall_request = 0;
            end
            else if (rx_gaps_on)
            begin
                n = gap_len();
            end
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_angles(int tgt, int meas, bit pin, int pin_drive, bit pin_mode);
        pinned_result_t p;
        int             n;
        p.on        = pin;
        p.res.drive = 16'(pin_drive);
        p.res.mode  = pin_mode;
        pinned_q.push_back(p);
        @(negedge clk);
        in_valid       <= 1'b1;
        target_angle   <= tgt[ANGLE_W-1:0];
        measured_angle <= meas[ANGLE_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        n = tx_gaps_on ? gap_len() : 0;
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_KP_TRANSIENT: cfg_kp_tr = val[GAIN_W-1:0];
            REG_KI_GAIN:      cfg_ki    = val[GAIN_W-1:0];
            REG_KP_STEADY:    cfg_kp_st = val[GAIN_W-1:0];
            REG_KD_GAIN:      cfg_kd    = val[GAIN_W-1:0];
            REG_ERROR_BAND:   cfg_band  = val[BAND_W-1:0];
            REG_STABLE_TICKS: cfg_ticks = val[TICKS_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic verify_registers();
        logic [DATA_W-1:0] want;
        logic [DATA_W-1:0] got;
        spd_reg_idx_t      idx;
        for (int i = REG_KP_TRANSIENT; i <= REG_STABLE_TICKS; i++)
        begin
            idx = spd_reg_idx_t'(i);
            case (idx)
                REG_KP_TRANSIENT: want = DATA_W'(cfg_kp_tr);
                REG_KI_GAIN:      want = DATA_W'(cfg_ki);
                REG_KP_STEADY:    want = DATA_W'(cfg_kp_st);
                REG_KD_GAIN:      want = DATA_W'(cfg_kd);
                REG_ERROR_BAND:   want = DATA_W'(cfg_band);
                default:          want = DATA_W'(cfg_ticks);
            endcase
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {idx, 2'b00};
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            got = prdata;
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", idx.name(), want, got);
                fail_count++;
            end
        end
    endtask

    task automatic apply_settings(int kpt, int ki, int kps, int kd, int band, int ticks);
        drain_results();
        write_register(REG_KP_TRANSIENT, kpt);
        write_register(REG_KI_GAIN, ki);
        write_register(REG_KP_STEADY, kps);
        write_register(REG_KD_GAIN, kd);
        write_register(REG_ERROR_BAND, band);
        write_register(REG_STABLE_TICKS, ticks);
        verify_registers();
    endtask

    initial
    begin
        int     aim;
        int     tgt;
        int     meas;
        int     span;
        int     r;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        target_angle   = '0;
        measured_angle = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        fail_count     = 0;
        cycle_count    = 0;
        stall_request  = 0;
        tx_gaps_on     = 1'b1;
        rx_gaps_on     = 1'b1;
        cfg_kp_tr      = KP_TRANSIENT_RST;
        cfg_ki         = KI_GAIN_RST;
        cfg_kp_st      = KP_STEADY_RST;
        cfg_kd         = KD_GAIN_RST;
        cfg_band       = ERROR_BAND_RST;
        cfg_ticks      = STABLE_TICKS_RST;
        prev_error     = 0;
        integ_acc      = 0;
        stable_run     = 0;

        plan.push_back(step_row(ROW_ITEM, 0, 0, 1, 0, 0));
        plan.push_back(step_row(ROW_ITEM, ANGLE_MAX, 0, 1, 25600, 0));
        plan.push_back(step_row(ROW_ITEM, 0, ANGLE_MAX, 1, -25600, 0));
        plan.push_back(step_row(ROW_ITEM, 92160, 92160, 1, 0, 0));
        plan.push_back(step_row(ROW_ITEM, 92160, 0, 1, 25600, 0));
        plan.push_back(step_row(ROW_ITEM, 0, 92160, 1, -25600, 0));
        plan.push_back(step_row(ROW_CFG, REG_STABLE_TICKS, 1, 0, 0, 0));
        plan.push_back(step_row(ROW_ITEM, 100, 0, 1, 25600, 1));
        plan.push_back(step_row(ROW_ITEM, 0, 100, 0, 0, 0));
        plan.push_back(step_row(ROW_CFG, REG_STABLE_TICKS, 0, 0, 0, 0));
        plan.push_back(step_row(ROW_ITEM, 5000, 0, 0, 0, 0));
        plan.push_back(step_row(ROW_CFG, REG_KP_STEADY, 0, 0, 0, 0));
        plan.push_back(step_row(ROW_CFG, REG_KD_GAIN, 0, 0, 0, 0));
        plan.push_back(step_row(ROW_ITEM, 77, 12345, 1, 0, 1));
        plan.push_back(step_row(ROW_CFG, REG_ERROR_BAND, 0, 0, 0, 0));
        plan.push_back(step_row(ROW_CFG, REG_UNMAPPED, 123, 0, 0, 0));
        plan.push_back(step_row(ROW_CFG, REG_KP_STEADY, 65535, 0, 0, 0));
        plan.push_back(step_row(ROW_CFG, REG_KD_GAIN, 65535, 0, 0, 0));
        plan.push_back(step_row(ROW_ITEM, 0, 0, 1, 25600, 1));
        plan.push_back(step_row(ROW_CFG, REG_KP_TRANSIENT, 65535, 0, 0, 0));
        plan.push_back(step_row(ROW_CFG, REG_KI_GAIN, 65535, 0, 0, 0));
        plan.push_back(step_row(ROW_CFG, REG_ERROR_BAND, ANGLE_MAX, 0, 0, 0));
        plan.push_back(step_row(ROW_CFG, REG_STABLE_TICKS, 255, 0, 0, 0));
        plan.push_back(step_row(ROW_ITEM, 1, 0, 0, 0, 0));
        plan.push_back(step_row(ROW_ITEM, 1, 0, 0, 0, 0));
        plan.push_back(step_row(ROW_ITEM, 1, 0, 0, 0, 0));
        plan.push_back(step_row(ROW_CFG, REG_STABLE_TICKS, 2, 0, 0, 0));
        plan.push_back(step_row(ROW_ITEM, 0, 1, 0, 0, 0));
        plan.push_back(step_row(ROW_CFG, REG_KP_TRANSIENT, 0, 0, 0, 0));
        plan.push_back(step_row(ROW_CFG, REG_KI_GAIN, 0, 0, 0, 0));
        plan.push_back(step_row(ROW_CFG, REG_STABLE_TICKS, 255, 0, 0, 0));
        plan.push_back(step_row(ROW_ITEM, ANGLE_MAX, 0, 1, 0, 0));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain_results();
                write_register(plan[i].a[IDX_W-1:0], plan[i].b);
                verify_registers();
            end
            else
            begin
                send_angles(plan[i].a, plan[i].b, plan[i].pinned, plan[i].drive,
                            plan[i].mode);
            end
        end

        aim = $urandom_range(0, ANGLE_MAX);
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: apply_settings(256, 26, 256, 26, 1280, 10);
                1: apply_settings(65535, 65535, 65535, 65535, 92160, 1);
                2: apply_settings(0, 0, 0, 0, ANGLE_MAX, 0);
                default: apply_settings($urandom_range(0, 1024), $urandom_range(0, 512),
                                        $urandom_range(0, 1024), $urandom_range(0, 512),
                                        $urandom_range(0, 3000), $urandom_range(0, 8));
            endcase
            tx_gaps_on = (phase != 1);
            rx_gaps_on = (phase != 1);
            // hold results back while transactions keep coming
            if (phase == 3)
                stall_request = HOLD_CYCLES;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 4 && k == 40)
                    drain_results();
                if ($urandom_range(0, 19) == 0)
                    aim = $urandom_range(0, ANGLE_MAX);
                r = $urandom_range(0, 9);
                if (r < 8)
                begin
                    span = (cfg_band > 4000) ? 3000 : (cfg_band * 3) / 4;
                    tgt  = aim;
                    meas = aim + $urandom_range(0, 2 * span) - span;
                    if (meas < 0)
                        meas = 0;
                    if (meas > ANGLE_MAX)
                        meas = ANGLE_MAX;
                end
                else
                begin
                    tgt  = $urandom_range(0, ANGLE_MAX);
                    meas = $urandom_range(0, ANGLE_MAX);
                end
                send_angles(tgt, meas, 0, 0, 0);
            end
        end

        // drive full-scale errors one way, then reverse them
        apply_settings(328, 1, 0, 0, 0, 255);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        repeat (4) send_angles(ANGLE_MAX, 0, 0, 0, 0);
        repeat (4) send_angles(0, ANGLE_MAX, 0, 0, 0);

        drain_results();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("switched_pi_pd_controller_top regression: pass");
        else
            $display("switched_pi_pd_controller_top regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
hdl/spd_pkg.sv
hdl/spd_regs.sv
hdl/spd_mac.sv
hdl/spd_div.sv
hdl/switched_pi_pd_controller_top.sv
tb/tb_switched_pi_pd_controller_top.sv
